// ===== rtl/core/fvn_pkg.sv =====
package fvn_pkg;

    // Fixed-point layout
    localparam int MAX_OCTAVES     = 8;
    localparam int COORD_FRAC_BITS = 16;
    localparam int FREQ_FRAC       = 12;
    localparam int CELL_LSB        = COORD_FRAC_BITS + FREQ_FRAC;
    localparam int FRAC_LSB        = CELL_LSB - 16;
    localparam int OCT_W           = 4;

    // Accumulator and amplitude-sum widths, shared with the divider
    localparam int TOT_W = 35;
    localparam int SUM_W = 20;
    localparam int CNT_W = 6;

    // Hash constants
    localparam logic [31:0] MIX_C1    = 32'h7feb352d;
    localparam logic [31:0] MIX_C2    = 32'h846ca68b;
    localparam logic [31:0] CX_OFS    = 32'h9e3779b9;
    localparam logic [31:0] CZ_OFS    = 32'h85ebca6b;
    localparam logic [31:0] SEED_STEP = 32'd1013;

    localparam logic signed [15:0] ONE_OUT = 16'sd16384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT_X,
        ST_SPLIT_Z,
        ST_FADE,
        ST_HASH,
        ST_BLEND,
        ST_ACC,
        ST_AMP,
        ST_FREQ,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        REG_SEED,
        REG_OCT,
        REG_PERS,
        REG_LAC
    } t_reg;

    // Top 16 hash bits to a value in -16384..16384: (top*32768+32767)/65535 - 16384
    function automatic logic signed [15:0] corner_value(input logic [15:0] top);
        logic [14:0] q1;
        logic [16:0] r1;
        logic [15:0] q;
        q1 = top[15:1];
        r1 = {1'b0, top[0], 15'h7fff} + {2'b00, q1};
        q  = {1'b0, q1} + ((r1 >= 17'd65535) ? 16'd1 : 16'd0);
        return $signed(q - 16'd16384);
    endfunction

endpackage

// ===== rtl/core/fvn_div.sv =====
module fvn_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fvn_pkg::TOT_W-1:0]     i_dividend,
    input  logic [fvn_pkg::SUM_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [fvn_pkg::TOT_W-1:0]     o_quot
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [fvn_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [fvn_pkg::SUM_W-1:0]   r_rem, n_rem;
    logic [fvn_pkg::TOT_W-1:0]   r_q, n_q;
    logic [fvn_pkg::SUM_W-1:0]   r_d, n_d;
    logic [fvn_pkg::SUM_W:0]     trial;
    logic                        ge;

    // One quotient bit per cycle, restoring
    always_comb begin
        trial  = {r_rem, r_q[fvn_pkg::TOT_W-1]};
        ge     = (trial >= {1'b0, r_d});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_q    = i_dividend;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? fvn_pkg::SUM_W'(trial - {1'b0, r_d}) : trial[fvn_pkg::SUM_W-1:0];
            n_q   = {r_q[fvn_pkg::TOT_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == fvn_pkg::CNT_W'(fvn_pkg::TOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/fractal_value_noise_2d.sv =====
// Fractal 2D value noise sampler.
// Input channel: i_in_valid / o_in_ready carry one signed Q16.16 coordinate
// pair (i_x_coord, i_z_coord). Output channel: o_out_valid / i_out_ready carry
// one normalized sample o_noise_value (1.0 = 16384).
// Configuration goes through the APB port: seed at 0x0, octave count at 0x4,
// persistence at 0x8, lacunarity at 0xC; write only while idle.
// Timing: one item at a time. Each octave runs its steps in turn on the shared
// 33x33 multiplier (2 coordinate splits, 8 fade products, 32 hash products,
// 3 lerps, accumulate, amplitude and frequency updates). The final
// normalization runs on a one-bit-per-cycle divider with a 35-bit quotient.
// Zero octaves go straight to the done state; o_in_ready is high only in
// the idle state.
// The result sits in an output register: the block returns to idle and takes
// the next item while it waits for i_out_ready; a finished item whose result
// cannot yet be stored waits in the done state.
// Reset (synchronous, active low) clears the sequencer and the output valid
// and loads seed 0, 4 octaves, persistence 0.5, lacunarity 2.0.
module fractal_value_noise_2d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_x_coord,
    input  logic signed [31:0] i_z_coord,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_noise_value
);

    function automatic logic signed [32:0] uext(input logic [31:0] v);
        return $signed({1'b0, v});
    endfunction

    // Configuration registers
    logic [31:0] r_seed;
    logic [3:0]  r_oct;
    logic [15:0] r_pers;
    logic [15:0] r_lac;

    // Sequencer
    fvn_pkg::t_state r_state, n_state;
    logic [4:0]      r_step, n_step;
    logic [3:0]      r_idx, n_idx;
    logic [3:0]      r_n, n_n;
    logic            r_out_valid, n_out_valid;

    // Datapath
    logic signed [31:0] r_x, n_x, r_z, n_z;
    logic [31:0] r_freq, n_freq;
    logic [16:0] r_amp, n_amp;
    logic [fvn_pkg::SUM_W-1:0] r_amp_sum, n_amp_sum;
    logic signed [fvn_pkg::TOT_W-1:0] r_total, n_total;
    logic [31:0] r_oseed, n_oseed;
    logic [31:0] r_cx, n_cx, r_cz, n_cz;
    logic [15:0] r_fx, n_fx, r_fz, n_fz;
    logic [15:0] r_fa, n_fa;
    logic [19:0] r_fp, n_fp;
    logic [16:0] r_sx, n_sx, r_sz, n_sz;
    logic [31:0] r_v, n_v, r_h, n_h;
    logic [15:0] r_top [4];
    logic [15:0] n_top [4];
    logic signed [16:0] r_b0, n_b0, r_b1, n_b1, r_samp, n_samp;
    logic signed [15:0] r_res, n_res, r_out, n_out;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    logic signed [15:0] cv [4];
    logic        cfg_wr;
    logic [15:0] frac_sel;
    logic signed [32:0] p_lin;
    logic [20:0] f_raw;
    logic signed [20:0] p_raw;
    logic [1:0]  k;
    logic [1:0]  j;
    logic [31:0] cxs, czs, mix_in, mix_pre, p32, mix_res;
    logic signed [16:0] d0, d1;
    logic signed [17:0] d2, s2;
    logic [35:0] f_next;
    logic [fvn_pkg::TOT_W-1:0] mag, dividend;
    logic        div_start, div_done;
    logic [fvn_pkg::TOT_W-1:0] div_quot;
    logic [15:0] q_clamp;
    logic        in_acc;
    logic        out_free;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    // Register read-back
    always_comb begin
        unique case (fvn_pkg::t_reg'(paddr[3:2]))
            fvn_pkg::REG_SEED: prdata = r_seed;
            fvn_pkg::REG_OCT:  prdata = {28'd0, r_oct};
            fvn_pkg::REG_PERS: prdata = {16'd0, r_pers};
            fvn_pkg::REG_LAC:  prdata = {16'd0, r_lac};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
            r_oct  <= 4'd4;
            r_pers <= 16'd32768;
            r_lac  <= 16'd8192;
        end else if (cfg_wr) begin
            unique case (fvn_pkg::t_reg'(paddr[3:2]))
                fvn_pkg::REG_SEED: r_seed <= pwdata;
                fvn_pkg::REG_OCT:  r_oct  <= pwdata[3:0];
                fvn_pkg::REG_PERS: r_pers <= pwdata[15:0];
                fvn_pkg::REG_LAC:  r_lac  <= pwdata[15:0];
            endcase
        end
    end

    // Corner values from stored hash tops
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cv[i] = fvn_pkg::corner_value(r_top[i]);
        end
    end

    // Operand decode
    always_comb begin
        frac_sel = r_step[2] ? r_fz : r_fx;
        p_lin   = $signed({15'd0, frac_sel, 2'b00}) + $signed({16'd0, frac_sel, 1'b0})
                  - 33'sd983040;
        k       = r_step[4:3];
        j       = r_step[2:1];
        cxs     = r_cx + {31'd0, k[0]};
        czs     = r_cz + {31'd0, k[1]};
        priority case (j)
            2'd0:    mix_in = cxs + fvn_pkg::CX_OFS;
            2'd2:    mix_in = czs + fvn_pkg::CZ_OFS;
            default: mix_in = r_h;
        endcase
        mix_pre = mix_in ^ (mix_in >> 16);
        d0      = 17'(cv[1]) - 17'(cv[0]);
        d1      = 17'(cv[3]) - 17'(cv[2]);
        d2      = 18'(r_b1) - 18'(r_b0);
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            fvn_pkg::ST_SPLIT_X: begin mul_a = 33'(r_x); mul_b = uext(r_freq); end
            fvn_pkg::ST_SPLIT_Z: begin mul_a = 33'(r_z); mul_b = uext(r_freq); end
            fvn_pkg::ST_FADE: begin
                unique case (r_step[1:0])
                    2'd0: begin mul_a = uext(32'(frac_sel)); mul_b = uext(32'(frac_sel)); end
                    2'd1: begin mul_a = uext(32'(r_fa));     mul_b = uext(32'(frac_sel)); end
                    2'd2: begin mul_a = p_lin;               mul_b = uext(32'(frac_sel)); end
                    2'd3: begin mul_a = uext(32'(r_fa));     mul_b = uext(32'(r_fp));     end
                endcase
            end
            fvn_pkg::ST_HASH: begin
                if (!r_step[0]) begin
                    mul_a = uext(mix_pre); mul_b = uext(fvn_pkg::MIX_C1);
                end else begin
                    mul_a = uext(r_v);     mul_b = uext(fvn_pkg::MIX_C2);
                end
            end
            fvn_pkg::ST_BLEND: begin
                priority case (r_step[1:0])
                    2'd0:    begin mul_a = 33'(d0); mul_b = uext(32'(r_sx)); end
                    2'd1:    begin mul_a = 33'(d1); mul_b = uext(32'(r_sx)); end
                    default: begin mul_a = 33'(d2); mul_b = uext(32'(r_sz)); end
                endcase
            end
            fvn_pkg::ST_ACC:  begin mul_a = 33'(r_samp);        mul_b = uext(32'(r_amp)); end
            fvn_pkg::ST_AMP:  begin mul_a = uext(32'(r_amp));   mul_b = uext(32'(r_pers)); end
            fvn_pkg::ST_FREQ: begin mul_a = uext(r_freq);       mul_b = uext(32'(r_lac)); end
            default: begin end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Post-processing of the product
    always_comb begin
        p32     = prod[31:0];
        mix_res = p32 ^ (p32 >> 16);
        p_raw   = prod[36:16];
        f_raw   = prod[36:16];
        s2      = 18'(r_b0) + prod[33:16];
        f_next  = prod[47:12];
        mag     = r_total[fvn_pkg::TOT_W-1] ? fvn_pkg::TOT_W'(-r_total)
                                            : fvn_pkg::TOT_W'(r_total);
        dividend = mag + fvn_pkg::TOT_W'(r_amp_sum[fvn_pkg::SUM_W-1:1]);
        q_clamp = (div_quot > fvn_pkg::TOT_W'(16384)) ? 16'd16384 : div_quot[15:0];
    end

    assign in_acc   = i_in_valid & o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_idx       = r_idx;
        n_n         = r_n;
        n_out_valid = r_out_valid;
        n_x = r_x; n_z = r_z;
        n_freq = r_freq; n_amp = r_amp; n_amp_sum = r_amp_sum; n_total = r_total;
        n_oseed = r_oseed;
        n_cx = r_cx; n_cz = r_cz; n_fx = r_fx; n_fz = r_fz;
        n_fa = r_fa; n_fp = r_fp; n_sx = r_sx; n_sz = r_sz;
        n_v = r_v; n_h = r_h;
        n_top = r_top;
        n_b0 = r_b0; n_b1 = r_b1; n_samp = r_samp;
        n_res = r_res; n_out = r_out;
        div_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fvn_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_x       = i_x_coord;
                    n_z       = i_z_coord;
                    n_n       = (r_oct > 4'(fvn_pkg::MAX_OCTAVES)) ?
                                4'(fvn_pkg::MAX_OCTAVES) : r_oct;
                    n_idx     = '0;
                    n_freq    = 32'd1 << fvn_pkg::FREQ_FRAC;
                    n_amp     = 17'd65536;
                    n_amp_sum = '0;
                    n_total   = '0;
                    n_oseed   = r_seed;
                    n_res     = '0;
                    n_step    = '0;
                    n_state   = (r_oct == 4'd0) ? fvn_pkg::ST_DONE : fvn_pkg::ST_SPLIT_X;
                end
            end
            fvn_pkg::ST_SPLIT_X: begin
                n_cx    = prod[fvn_pkg::CELL_LSB+31:fvn_pkg::CELL_LSB];
                n_fx    = prod[fvn_pkg::CELL_LSB-1:fvn_pkg::FRAC_LSB];
                n_state = fvn_pkg::ST_SPLIT_Z;
            end
            fvn_pkg::ST_SPLIT_Z: begin
                n_cz    = prod[fvn_pkg::CELL_LSB+31:fvn_pkg::CELL_LSB];
                n_fz    = prod[fvn_pkg::CELL_LSB-1:fvn_pkg::FRAC_LSB];
                n_step  = '0;
                n_state = fvn_pkg::ST_FADE;
            end
            fvn_pkg::ST_FADE: begin
                // t^2, t^3, t*(6t-15)+10, then the product clamped to one
                unique case (r_step[1:0])
                    2'd0: n_fa = prod[31:16];
                    2'd1: n_fa = prod[31:16];
                    2'd2: n_fp = 20'(p_raw + 21'sd655360);
                    2'd3: begin
                        if (r_step[2]) n_sz = (f_raw > 21'd65536) ? 17'd65536 : f_raw[16:0];
                        else           n_sx = (f_raw > 21'd65536) ? 17'd65536 : f_raw[16:0];
                    end
                endcase
                n_step = r_step + 5'd1;
                if (r_step == 5'd7) begin
                    n_step  = '0;
                    n_state = fvn_pkg::ST_HASH;
                end
            end
            fvn_pkg::ST_HASH: begin
                // Four mixes per corner, two products each
                if (!r_step[0]) begin
                    n_v = p32 ^ (p32 >> 15);
                end else begin
                    unique case (j)
                        2'd0: n_h = r_oseed ^ mix_res;
                        2'd1: n_h = mix_res;
                        2'd2: n_h = r_h ^ mix_res;
                        2'd3: n_top[k] = mix_res[31:16];
                    endcase
                end
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_step  = '0;
                    n_state = fvn_pkg::ST_BLEND;
                end
            end
            fvn_pkg::ST_BLEND: begin
                priority case (r_step[1:0])
                    2'd0: n_b0 = 17'(cv[0]) + prod[32:16];
                    2'd1: n_b1 = 17'(cv[2]) + prod[32:16];
                    default: begin
                        n_samp  = s2[16:0];
                        n_state = fvn_pkg::ST_ACC;
                    end
                endcase
                n_step = r_step + 5'd1;
            end
            fvn_pkg::ST_ACC: begin
                n_total   = r_total + prod[fvn_pkg::TOT_W-1:0];
                n_amp_sum = r_amp_sum + fvn_pkg::SUM_W'(r_amp);
                n_state   = fvn_pkg::ST_AMP;
            end
            fvn_pkg::ST_AMP: begin
                n_amp   = prod[32:16];
                n_state = fvn_pkg::ST_FREQ;
            end
            fvn_pkg::ST_FREQ: begin
                n_freq  = (f_next[35:32] != 4'd0) ? 32'hFFFF_FFFF : f_next[31:0];
                n_oseed = r_oseed + fvn_pkg::SEED_STEP;
                n_idx   = r_idx + 4'd1;
                if (r_idx + 4'd1 == r_n) begin
                    div_start = 1'b1;
                    n_state   = fvn_pkg::ST_DIV;
                end else begin
                    n_state = fvn_pkg::ST_SPLIT_X;
                end
            end
            fvn_pkg::ST_DIV: begin
                if (div_done) begin
                    n_res   = r_total[fvn_pkg::TOT_W-1] ? $signed(-q_clamp) : $signed(q_clamp);
                    n_state = fvn_pkg::ST_DONE;
                end
            end
            fvn_pkg::ST_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = fvn_pkg::ST_IDLE;
                end
            end
            default: n_state = fvn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fvn_pkg::ST_IDLE;
            r_step      <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_z <= n_z;
        r_freq <= n_freq; r_amp <= n_amp; r_amp_sum <= n_amp_sum; r_total <= n_total;
        r_oseed <= n_oseed;
        r_cx <= n_cx; r_cz <= n_cz; r_fx <= n_fx; r_fz <= n_fz;
        r_fa <= n_fa; r_fp <= n_fp; r_sx <= n_sx; r_sz <= n_sz;
        r_v <= n_v; r_h <= n_h;
        r_top <= n_top;
        r_b0 <= n_b0; r_b1 <= n_b1; r_samp <= n_samp;
        r_res <= n_res; r_out <= n_out;
    end

    // Normalization by the amplitude sum
    fvn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (n_amp_sum),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_in_ready    = (r_state == fvn_pkg::ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out;

endmodule

// ===== rtl/core/fvn_chk.sv =====
module fvn_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] o_noise_value
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_noise_value))
        else $error("result dropped or changed while stalled");

    // Results stay within -1..1
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_noise_value <= 16'sd16384 && o_noise_value >= -16'sd16384))
        else $error("result out of range");

    // An accepted item keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind fractal_value_noise_2d fvn_chk u_fvn_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_noise_value (o_noise_value)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    // Clock and reset
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_x_coord = '0;
    logic signed [31:0] i_z_coord = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_noise_value;

    always #10 i_clk = ~i_clk;

    fractal_value_noise_2d dut (.*);

    // Shadow copy of the configuration registers
    logic [31:0] cfg_seed;
    logic [3:0]  cfg_oct;
    logic [15:0] cfg_pers;
    logic [15:0] cfg_lac;

    logic signed [15:0] noise_q[$];
    int errors = 0;
    int mismatches = 0;
    bit quiet = 0;       // long stretch with no idling
    bit sink_hold = 0;   // receiver stall while sender pauses

    function automatic logic [31:0] mix32(input logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * fvn_pkg::MIX_C1;
        v = v ^ (v >> 15);
        v = v * fvn_pkg::MIX_C2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic longint corner_val(input logic [31:0] cx, input logic [31:0] cz,
                                          input logic [31:0] seed);
        logic [31:0] h;
        longint top;
        h = seed;
        h = h ^ mix32(cx + fvn_pkg::CX_OFS);
        h = mix32(h);
        h = h ^ mix32(cz + fvn_pkg::CZ_OFS);
        h = mix32(h);
        top = h[31:16];
        return (top * 32768 + 32767) / 65535 - 16384;
    endfunction

    function automatic longint fade_q(input longint t);
        longint t2, t3, p, f;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        p = 6 * t - 15 * 65536;
        p = ((p * t) >>> 16) + 10 * 65536;
        f = (t3 * p) >>> 16;
        if (f < 0) f = 0;
        if (f > 65536) f = 65536;
        return f;
    endfunction

    function automatic longint lerp_q(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    // Scaled coordinate: cell index (floor, mod 2^32) and Q0.16 fraction
    function automatic void split_coord(input logic signed [31:0] c, input logic [31:0] freq,
                                        output logic [31:0] cell_idx, output longint frac);
        longint p;
        p = longint'(c) * longint'({32'd0, freq});
        cell_idx = p >>> fvn_pkg::CELL_LSB;
        frac = (p >> fvn_pkg::FRAC_LSB) & 64'hFFFF;
    endfunction

    function automatic logic signed [15:0] noise_predict(input logic signed [31:0] x,
                                                         input logic signed [31:0] z);
        int n;
        logic [31:0] freq, cx, cz;
        longint amp, amp_sum, total, fx, fz, sx, sz, r0, r1, mag, q, res, nf;
        n = (cfg_oct > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : cfg_oct;
        freq = 32'd4096;
        amp = 65536;
        amp_sum = 0;
        total = 0;
        res = 0;
        for (int i = 0; i < n; i++) begin
            split_coord(x, freq, cx, fx);
            split_coord(z, freq, cz, fz);
            sx = fade_q(fx);
            sz = fade_q(fz);
            r0 = lerp_q(corner_val(cx, cz, cfg_seed + i * fvn_pkg::SEED_STEP),
                        corner_val(cx + 1, cz, cfg_seed + i * fvn_pkg::SEED_STEP), sx);
            r1 = lerp_q(corner_val(cx, cz + 1, cfg_seed + i * fvn_pkg::SEED_STEP),
                        corner_val(cx + 1, cz + 1, cfg_seed + i * fvn_pkg::SEED_STEP), sx);
            total += lerp_q(r0, r1, sz) * amp;
            amp_sum += amp;
            amp = (amp * cfg_pers) >> 16;
            nf = (longint'({32'd0, freq}) * cfg_lac) >> fvn_pkg::FREQ_FRAC;
            freq = (nf > 64'hFFFFFFFF) ? 32'hFFFFFFFF : nf[31:0];
        end
        if (amp_sum > 0) begin
            mag = (total < 0) ? -total : total;
            q = (mag + amp_sum / 2) / amp_sum;
            res = (total < 0) ? -q : q;
            if (res > 16384) res = 16384;
            if (res < -16384) res = -16384;
        end
        return res[15:0];
    endfunction

    // Register write over APB: setup phase, access phase, then back to idle
    task automatic reg_write(input fvn_pkg::t_reg idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            fvn_pkg::REG_SEED: cfg_seed = val;
            fvn_pkg::REG_OCT:  cfg_oct = val[3:0];
            fvn_pkg::REG_PERS: cfg_pers = val[15:0];
            fvn_pkg::REG_LAC:  cfg_lac = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Send one item, optionally with a fixed expected value
    task automatic send_item(input logic [31:0] x, input logic [31:0] z,
                             input bit fixed, input logic signed [15:0] want);
        while (!quiet && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x_coord <= x;
        i_z_coord <= z;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        noise_q.push_back(fixed ? want : noise_predict(x, z));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (noise_q.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    // Receiver ready
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold) i_out_ready <= 1'b0;
        else i_out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 25);
    end

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (noise_q.size() == 0) begin
                errors++;
                $display("unexpected noise item %0d", o_noise_value);
            end else begin
                if (o_noise_value !== noise_q[0]) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d actual %0d",
                                 noise_q[0], o_noise_value);
                end
                void'(noise_q.pop_front());
            end
        end
    end

    typedef struct {
        logic [31:0] x;
        logic [31:0] z;
        logic [3:0]  oct;
        logic [31:0] seed;
        logic [15:0] pers;
        logic [15:0] lac;
        bit          fixed;
        logic [15:0] want;
    } t_stim_row;

    // Directed rows: reset settings, zero octaves, saturated count with zero
    // lacunarity, frequency saturation, full octaves at full persistence
    t_stim_row rows [16] = '{
        '{32'h0000_0000, 32'h0000_0000, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h8000_0000, 32'h8000_0000, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'hFFFF_FFFF, 32'h0000_0001, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h0000_8000, 32'hFFFF_8000, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h0001_0000, 32'hFFFF_0000, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 4'd4, 32'h0, 16'h8000, 16'h2000, 1'b0, 16'h0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 4'd0, 32'h0, 16'h8000, 16'h2000, 1'b1, 16'h0},
        '{32'h0003_4000, 32'hFFF1_0000, 4'd0, 32'h0, 16'h8000, 16'h2000, 1'b1, 16'h0},
        '{32'h0005_8000, 32'hFFFD_2000, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
          1'b0, 16'h0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
          1'b0, 16'h0},
        '{32'h7FFF_FFFF, 32'h8000_0001, 4'd15, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
          1'b0, 16'h0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
          1'b0, 16'h0},
        '{32'h4000_0000, 32'hC000_0000, 4'd8, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 16'h0},
        '{32'h0000_FFFF, 32'hFFFF_0001, 4'd8, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
          1'b0, 16'h0}
    };

    initial begin
        logic [31:0] x, z;
        cfg_seed = 0; cfg_oct = 4; cfg_pers = 16'd32768; cfg_lac = 16'd8192;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; settings change only with nothing in flight
        foreach (rows[i]) begin
            if (rows[i].oct !== cfg_oct || rows[i].seed !== cfg_seed ||
                rows[i].pers !== cfg_pers || rows[i].lac !== cfg_lac) begin
                drain();
                reg_write(fvn_pkg::REG_SEED, rows[i].seed);
                reg_write(fvn_pkg::REG_OCT, {28'd0, rows[i].oct});
                reg_write(fvn_pkg::REG_PERS, {16'd0, rows[i].pers});
                reg_write(fvn_pkg::REG_LAC, {16'd0, rows[i].lac});
            end
            send_item(rows[i].x, rows[i].z, rows[i].fixed, rows[i].want);
        end
        drain();

        // Random phases with random settings; mostly few octaves for speed
        for (int ph = 0; ph < 17; ph++) begin
            reg_write(fvn_pkg::REG_SEED, $urandom);
            reg_write(fvn_pkg::REG_OCT, ($urandom_range(9) == 0) ? $urandom_range(15, 8)
                                                                 : $urandom_range(3));
            reg_write(fvn_pkg::REG_PERS, $urandom_range(65535));
            reg_write(fvn_pkg::REG_LAC, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                 : $urandom_range(16384));
            quiet = (ph == 5);
            for (int k = 0; k < 50; k++) begin
                case ($urandom_range(3))
                    0: begin x = $urandom; z = $urandom; end
                    1: begin x = $urandom_range(32'h000F_FFFF); z = -$urandom_range(32'h000F_FFFF); end
                    2: begin x = {{16{1'b0}}, 16'($urandom)}; z = {{16{1'b1}}, 16'($urandom)}; end
                    default: begin x = $urandom ^ 32'h8000_0000; z = $urandom & 32'h8000_FFFF; end
                endcase
                // Sender pause until all results are back, with receiver stalled first
                if (ph == 3 && k == 25) begin
                    i_in_valid <= 1'b0;
                    sink_hold = 1;
                    repeat (200) @(posedge i_clk);
                    sink_hold = 0;
                    while (noise_q.size() != 0) @(posedge i_clk);
                end
                send_item(x, z, 1'b0, 0);
            end
            quiet = 0;
            drain();
        end

        if (errors == 0 && noise_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
